FILE: rtl/core/mvo_pkg.sv
`timescale 1ns / 1ps
// mvo_pkg: shared types, register indexes, wave codes and the sine table
// generator for the multi-voice oscillator. No dependencies.
package mvo_pkg;

  localparam int SUM_W = 18;
  localparam int STEP_W = 24;
  localparam int FREQ_W = 32;
  localparam int PHASE_W = 32;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_COUNT = 4;

  localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SELECTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ3 = 3'd5;

  localparam logic [2:0] WAVE_SILENT = 3'd0;
  localparam logic [2:0] WAVE_SIN = 3'd1;
  localparam logic [2:0] WAVE_SAW = 3'd2;
  localparam logic [2:0] WAVE_SQR = 3'd3;
  localparam logic [2:0] WAVE_TRI = 3'd4;

  localparam logic signed [SAMPLE_W-1:0] UNITY = 16'sd32767;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // step word travelling down the chain
  typedef struct packed {
    logic tok;
    logic [STEP_W-1:0] step;
  } link_t;

  // running sum travelling down the chain
  typedef struct packed {
    logic vld;
    sum_t sum;
  } acc_t;

  // unsigned long division, shift and subtract
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    begin
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        r = {r[62:0], n[b]};
        if (r >= d) begin
          r = r - d;
          q[b] = 1'b1;
        end
      end
      udiv64 = q;
    end
  endfunction

  // quarter-wave entry, integer Taylor series in Q30
  function automatic logic [14:0] sine_entry(input int idx, input int bits);
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint v;
    begin
      x = longint'((HALF_PI_Q30 * longint'(idx)) >>> bits);
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 12; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = udiv64(term, longint'((2 * k) * (2 * k + 1)));
        if ((k & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
      if (v > 32767) begin
        v = 32767;
      end
      sine_entry = v[14:0];
    end
  endfunction

endpackage

FILE: rtl/core/mvo_rom.sv
`timescale 1ns / 1ps
// mvo_rom: quarter-wave sine table with registered read.
// Depends on mvo_pkg (sine_entry).
module mvo_rom #(
  parameter int BITS = 10
) (
  input  logic              clk,
  input  logic [BITS:0]     addr,
  output logic [14:0]       q_r
);

  localparam int N = 1 << BITS;

  typedef logic [14:0] tab_t [0:N];

  function automatic tab_t build_tab();
    tab_t t;
    begin
      for (int i = 0; i <= N; i++) begin
        t[i] = mvo_pkg::sine_entry(i, BITS);
      end
      build_tab = t;
    end
  endfunction

  localparam tab_t TAB = build_tab();

  always_ff @(posedge clk) begin
    q_r <= TAB[addr];
  end

endmodule

FILE: rtl/core/mvo_cell.sv
`timescale 1ns / 1ps
// mvo_cell: one voice of the chain; holds its phase, forms its waveform
// and adds it to the running sum. Depends on mvo_pkg and mvo_rom.
module mvo_cell #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          active,
  input  logic [2:0]                    code,
  input  logic [mvo_pkg::FREQ_W-1:0]    freq,
  input  mvo_pkg::link_t                lnk_in,
  input  mvo_pkg::acc_t                 acc_in,
  output mvo_pkg::link_t                lnk_out,
  output mvo_pkg::acc_t                 acc_out
);

  localparam int AW = SINE_TABLE_BITS + 1;

  logic                              v1_r, v2_r, v3_r, sv_r;
  logic [mvo_pkg::STEP_W-1:0]        step_r;
  logic [mvo_pkg::PHASE_W-1:0]       prod_r;
  logic [mvo_pkg::PHASE_W-1:0]       phase_r;
  logic [mvo_pkg::STEP_W+mvo_pkg::FREQ_W-1:0] prod_full;
  logic [SINE_TABLE_BITS-1:0]        idx;
  logic [AW-1:0]                     rom_addr;
  logic [14:0]                       rom_q;
  logic signed [17:0]                s, a, tri_raw;
  mvo_pkg::sample_t                  saw_v, sq_v, tri_v, w_nxt, w_r, val;
  logic                              sine_r, neg_r;
  mvo_pkg::sum_t                     sum_r;

  assign prod_full = lnk_in.step * freq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      sv_r <= 1'b0;
      phase_r <= '0;
    end else begin
      v1_r <= lnk_in.tok;
      v2_r <= v1_r;
      v3_r <= v2_r;
      sv_r <= v3_r;
      if (v1_r && active) begin
        phase_r <= phase_r + prod_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lnk_in.tok) begin
      step_r <= lnk_in.step;
      prod_r <= prod_full[mvo_pkg::PHASE_W+7:8];
    end
  end

  // table lookup, mirrored in odd quadrants
  assign idx = phase_r[29 -: SINE_TABLE_BITS];
  assign rom_addr = phase_r[30] ? (AW'(1) << SINE_TABLE_BITS) - {1'b0, idx}
                                : {1'b0, idx};

  mvo_rom #(.BITS(SINE_TABLE_BITS)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q_r  (rom_q)
  );

  always_comb begin
    s = $signed({2'b00, phase_r[31:16]}) - 18'sd32768;
    a = s[17] ? -s : s;
    tri_raw = (a <<< 1) - 18'sd32768;
    saw_v = (s < -18'sd32767) ? -mvo_pkg::UNITY : mvo_pkg::sample_t'(s);
    sq_v = (phase_r != '0 && !phase_r[31]) ? mvo_pkg::UNITY : -mvo_pkg::UNITY;
    if (tri_raw > 18'sd32767) begin
      tri_v = mvo_pkg::UNITY;
    end else if (tri_raw < -18'sd32767) begin
      tri_v = -mvo_pkg::UNITY;
    end else begin
      tri_v = mvo_pkg::sample_t'(tri_raw);
    end
    case (code)
      mvo_pkg::WAVE_SAW: w_nxt = saw_v;
      mvo_pkg::WAVE_SQR: w_nxt = sq_v;
      mvo_pkg::WAVE_TRI: w_nxt = tri_v;
      default:           w_nxt = '0;
    endcase
    if (!active) begin
      w_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      w_r <= w_nxt;
      sine_r <= active && (code == mvo_pkg::WAVE_SIN);
      neg_r <= phase_r[31];
    end
  end

  always_comb begin
    if (sine_r) begin
      val = neg_r ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
    end else begin
      val = w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      sum_r <= acc_in.sum + mvo_pkg::SUM_W'(val);
    end
  end

  assign lnk_out = '{tok: v1_r, step: step_r};
  assign acc_out = '{vld: sv_r, sum: sum_r};

endmodule

FILE: rtl/core/multi_voice_waveform_oscillator.sv
`timescale 1ns / 1ps
// Multi-voice waveform oscillator, top level: registers, voice chain, mixer.
// A word goes from the input register down the voice cells, one voice cell per
// cycle, then through the divide stage and result register to the output.
// A new word is taken only once the last result has moved to the output stage.
// Reset (synchronous, rst_n low): phases 0, voice_count 1, waves and
// frequencies 0, both channels empty. Depends on mvo_pkg and mvo_cell.
module multi_voice_waveform_oscillator #(
  parameter int VOICES = 4,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mvo_pkg::STEP_W-1:0]         in_time_step,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mvo_pkg::SAMPLE_W-1:0] out_mixed_sample,
  input  logic                               cfg_we,
  input  logic [mvo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mvo_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [2:0]                   vc_r;
  logic [11:0]                  ws_r;
  logic [mvo_pkg::FREQ_W-1:0]   freq_r [mvo_pkg::REG_COUNT];
  logic [2:0]                   nc;
  logic                         busy_r, d1v_r, res_v_r, out_v_r, mv, acc_in_w;
  logic                         tok_r;
  logic [mvo_pkg::STEP_W-1:0]   step_r;
  mvo_pkg::link_t               lnk [VOICES+1];
  mvo_pkg::acc_t                acc [VOICES+1];
  logic [16:0]                  abs_r;
  logic                         neg_r;
  logic [33:0]                  prod3;
  logic [15:0]                  q;
  mvo_pkg::sample_t             res_r, out_r;

  assign acc_in_w = in_valid && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 3'd1;
      ws_r <= '0;
      for (int i = 0; i < mvo_pkg::REG_COUNT; i++) begin
        freq_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        mvo_pkg::REG_VOICE_COUNT:  vc_r <= cfg_data[2:0];
        mvo_pkg::REG_WAVE_SELECTS: ws_r <= cfg_data[11:0];
        mvo_pkg::REG_FREQ0:        freq_r[0] <= cfg_data;
        mvo_pkg::REG_FREQ1:        freq_r[1] <= cfg_data;
        mvo_pkg::REG_FREQ2:        freq_r[2] <= cfg_data;
        mvo_pkg::REG_FREQ3:        freq_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vc_r == 3'd0) begin
      nc = 3'd1;
    end else if (vc_r > 3'(VOICES)) begin
      nc = 3'(VOICES);
    end else begin
      nc = vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      tok_r <= acc_in_w;
      if (acc_in_w) begin
        busy_r <= 1'b1;
      end else if (mv) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in_w) begin
      step_r <= in_time_step;
    end
  end

  assign lnk[0] = '{tok: tok_r, step: step_r};
  assign acc[0] = '{vld: 1'b0, sum: '0};

  for (genvar v = 0; v < VOICES; v++) begin : g_cell
    mvo_cell #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .active  (3'(v) < nc),
      .code    (ws_r[3*v +: 3]),
      .freq    (freq_r[v]),
      .lnk_in  (lnk[v]),
      .acc_in  (acc[v]),
      .lnk_out (lnk[v+1]),
      .acc_out (acc[v+1])
    );
  end

  // mix: |sum| / n, sign restored, truncation toward zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1v_r <= 1'b0;
    end else begin
      d1v_r <= acc[VOICES].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (acc[VOICES].vld) begin
      neg_r <= acc[VOICES].sum[mvo_pkg::SUM_W-1];
      abs_r <= acc[VOICES].sum[mvo_pkg::SUM_W-1] ? 17'(-acc[VOICES].sum)
                                                 : 17'(acc[VOICES].sum);
    end
  end

  assign prod3 = {17'd0, abs_r} * 34'd43691;

  always_comb begin
    case (nc)
      3'd1:    q = abs_r[15:0];
      3'd2:    q = abs_r[16:1];
      3'd3:    q = prod3[32:17];
      default: q = {1'b0, abs_r[16:2]};
    endcase
  end

  assign mv = res_v_r && (!out_v_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (d1v_r) begin
        res_v_r <= 1'b1;
      end else if (mv) begin
        res_v_r <= 1'b0;
      end
      if (mv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d1v_r) begin
      res_r <= neg_r ? -$signed(q) : $signed(q);
    end
    if (mv) begin
      out_r <= res_r;
    end
  end

  assign in_stall = busy_r;
  assign out_valid = out_v_r;
  assign out_mixed_sample = out_r;

  a_sum_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    acc[VOICES].vld |-> busy_r)
    else $error("chain sum with no word in flight");

  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r |-> busy_r && !tok_r)
    else $error("mixer result pending while a new word entered");

  a_no_neg_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r != 16'sh8000)
    else $error("mix exceeded unity");

endmodule
